// ===== rtl/core/place_fingerprint_catalog_match_unit_assert.svh =====
// assertion macros for the place catalog match unit
`ifndef PLACE_FINGERPRINT_CATALOG_MATCH_UNIT_ASSERT_SVH
`define PLACE_FINGERPRINT_CATALOG_MATCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PFCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfcm assertion failed");
`define PFCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfcm assertion failed");
`else
`define PFCM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PFCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/pfcm_pkg.sv =====
`timescale 1ns / 1ps
package pfcm_pkg;

  localparam int unsigned TOKENS_PER_PLACE = 8;
  localparam int unsigned CATALOG_DEPTH    = 64;
  localparam int unsigned TOKEN_W          = 32;
  localparam int unsigned PLACE_W          = 6;
  localparam int unsigned SLOT_W           = 3;
  localparam int unsigned CNT_W            = 4;
  localparam int unsigned ID_W             = 16;
  localparam int unsigned SCORE_W          = 10;
  localparam int unsigned LIMIT_W          = 7;

  localparam logic [SCORE_W-1:0] SCORE_SCALE = 10'd1000;
  localparam logic [CNT_W-1:0]   MAX_TOKENS  = 4'd8;
  localparam logic [LIMIT_W-1:0] MAX_PLACES  = 7'd64;

  localparam logic [1:0] CMD_CAT_TOKEN = 2'd0;
  localparam logic [1:0] CMD_HEADER    = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  localparam logic [1:0] REL_NEW   = 2'd0;
  localparam logic [1:0] REL_GRAY  = 2'd1;
  localparam logic [1:0] REL_KNOWN = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [PLACE_W-1:0] entry_index;
    logic [SLOT_W-1:0]  slot;
    logic [TOKEN_W-1:0] token;
    logic [ID_W-1:0]    loc_id;
    logic [CNT_W-1:0]   token_count;
    logic               last;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [PLACE_W-1:0] best_index;
    logic [ID_W-1:0]    best_loc_id;
    logic [SCORE_W-1:0] best_score;
    logic [1:0]         relation;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic               cat_we;
    logic               hdr_we;
    logic               q_load;
    logic               clr_best;
    logic               hdr_rd;
    logic               tok_rd;
    logic [PLACE_W-1:0] place;
    logic [SLOT_W-1:0]  slot;
    logic               clr_hits;
    logic               acc_en;
    logic [SLOT_W-1:0]  acc_slot;
    logic               score_en;
    logic               cmp_en;
    logic               first;
    logic               done;
  } dp_cmd_t;

  typedef struct packed {
    logic q_usable_next;
  } dp_stat_t;

  function automatic logic usable(input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] min_n);
    usable = (n >= min_n) && (n <= MAX_TOKENS);
  endfunction

  // floor(1000 * hits / den), saturated, den of zero gives zero
  // divisors 3, 5, 6 and 7 by reciprocal multiply, exact for every 14-bit product
  function automatic logic [SCORE_W-1:0] score_of(input logic [CNT_W-1:0] hits,
                                                  input logic [CNT_W-1:0] den);
    logic [13:0] prod;
    logic [30:0] recip;
    logic [13:0] q;
    prod  = 14'(hits) * 14'd1000;
    recip = '0;
    unique case (den)
      4'd1:    q = prod;
      4'd2:    q = prod >> 1;
      4'd3: begin
        recip = 31'(prod) * 31'd43691;
        q     = 14'(recip >> 17);
      end
      4'd4:    q = prod >> 2;
      4'd5: begin
        recip = 31'(prod) * 31'd26215;
        q     = 14'(recip >> 17);
      end
      4'd6: begin
        recip = 31'(prod) * 31'd21846;
        q     = 14'(recip >> 17);
      end
      4'd7: begin
        recip = 31'(prod) * 31'd18725;
        q     = 14'(recip >> 17);
      end
      4'd8:    q = prod >> 3;
      default: q = '0;
    endcase
    score_of = (q > 14'(SCORE_SCALE)) ? SCORE_SCALE : q[SCORE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/pfcm_ram.sv =====
`timescale 1ns / 1ps
module pfcm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pfcm_ctrl.sv =====
`timescale 1ns / 1ps
module pfcm_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [1:0]                       command_i,
  input  logic                             last_i,
  input  logic [pfcm_pkg::LIMIT_W-1:0]     catalog_count_i,
  input  pfcm_pkg::dp_stat_t               stat_i,
  output pfcm_pkg::dp_cmd_t                cmd_o,
  output logic                             busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_SCORE = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [pfcm_pkg::PLACE_W-1:0]    place_q, place_d;
  logic [pfcm_pkg::SLOT_W:0]       slot_q, slot_d;
  logic [pfcm_pkg::LIMIT_W-1:0]    limit;
  logic                            accept;

  assign limit  = (catalog_count_i > pfcm_pkg::MAX_PLACES) ? pfcm_pkg::MAX_PLACES
                                                            : catalog_count_i;
  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    place_d = place_q;
    slot_d  = slot_q;
    cmd_o   = '0;
    cmd_o.place    = place_q;
    cmd_o.slot     = slot_q[pfcm_pkg::SLOT_W-1:0];
    cmd_o.acc_slot = pfcm_pkg::SLOT_W'(slot_q - 1'b1);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.cat_we = accept && (command_i == pfcm_pkg::CMD_CAT_TOKEN);
        cmd_o.hdr_we = accept && (command_i == pfcm_pkg::CMD_HEADER);
        cmd_o.q_load = accept && (command_i == pfcm_pkg::CMD_QUERY);
        if (cmd_o.q_load && last_i) begin
          cmd_o.clr_best = 1'b1;
          place_d        = '0;
          state_d        = (stat_i.q_usable_next && (limit != '0)) ? S_ISSUE : S_DONE;
        end
      end
      S_ISSUE: begin
        cmd_o.hdr_rd   = 1'b1;
        cmd_o.tok_rd   = 1'b1;
        cmd_o.slot     = '0;
        cmd_o.clr_hits = 1'b1;
        slot_d         = (pfcm_pkg::SLOT_W+1)'(1);
        state_d        = S_RUN;
      end
      S_RUN: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.tok_rd = (slot_q < (pfcm_pkg::SLOT_W+1)'(pfcm_pkg::TOKENS_PER_PLACE));
        slot_d       = slot_q + 1'b1;
        if (slot_q == (pfcm_pkg::SLOT_W+1)'(pfcm_pkg::TOKENS_PER_PLACE)) begin
          state_d = S_SCORE;
        end
      end
      S_SCORE: begin
        cmd_o.score_en = 1'b1;
        state_d        = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp_en = 1'b1;
        cmd_o.first  = (place_q == '0);
        if ({1'b0, place_q} == (limit - 1'b1)) begin
          state_d = S_DONE;
        end else begin
          place_d = place_q + 1'b1;
          state_d = S_ISSUE;
        end
      end
      S_DONE: begin
        cmd_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      place_q <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      place_q <= place_d;
      slot_q  <= slot_d;
    end
  end

endmodule

// ===== rtl/core/pfcm_dp.sv =====
`timescale 1ns / 1ps
module pfcm_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfcm_pkg::dp_cmd_t              cmd_i,
  input  pfcm_pkg::item_t                item_i,
  input  logic [pfcm_pkg::CNT_W-1:0]     min_usable_i,
  input  logic [pfcm_pkg::SCORE_W-1:0]   known_threshold_i,
  input  logic [pfcm_pkg::SCORE_W-1:0]   new_threshold_i,
  output pfcm_pkg::dp_stat_t             stat_o,
  output pfcm_pkg::result_t              result_o,
  output logic                           result_valid_o
);

  localparam int unsigned TADDR_W = pfcm_pkg::PLACE_W + pfcm_pkg::SLOT_W;
  localparam int unsigned HDR_W   = pfcm_pkg::ID_W + pfcm_pkg::CNT_W;

  logic [pfcm_pkg::TOKEN_W-1:0] q_tok_q [pfcm_pkg::TOKENS_PER_PLACE];
  logic [pfcm_pkg::CNT_W-1:0]   qsize_q, qsize_next;
  logic [pfcm_pkg::CNT_W-1:0]   hits_q;
  logic [pfcm_pkg::SCORE_W-1:0] score_q;
  logic                         found_q;
  logic [pfcm_pkg::PLACE_W-1:0] best_idx_q;
  logic [pfcm_pkg::SCORE_W-1:0] best_score_q;
  logic [pfcm_pkg::ID_W-1:0]    best_id_q;
  pfcm_pkg::result_t            result_q;
  logic                         valid_q;

  logic [pfcm_pkg::TOKEN_W-1:0] tok_rdata;
  logic [HDR_W-1:0]             hdr_rdata;
  logic [pfcm_pkg::ID_W-1:0]    hdr_id;
  logic [pfcm_pkg::CNT_W-1:0]   hdr_cnt;
  logic [pfcm_pkg::CNT_W-1:0]   den;
  logic                         match;

  pfcm_ram #(.WIDTH(pfcm_pkg::TOKEN_W), .DEPTH(pfcm_pkg::CATALOG_DEPTH *
             pfcm_pkg::TOKENS_PER_PLACE)) u_tok_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cat_we),
    .waddr_i ({item_i.entry_index, item_i.slot}),
    .wdata_i (item_i.token),
    .re_i    (cmd_i.tok_rd),
    .raddr_i (TADDR_W'({cmd_i.place, cmd_i.slot})),
    .rdata_o (tok_rdata)
  );

  pfcm_ram #(.WIDTH(HDR_W), .DEPTH(pfcm_pkg::CATALOG_DEPTH)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hdr_we),
    .waddr_i (item_i.entry_index),
    .wdata_i ({item_i.loc_id, item_i.token_count}),
    .re_i    (cmd_i.hdr_rd),
    .raddr_i (cmd_i.place),
    .rdata_o (hdr_rdata)
  );

  assign hdr_id  = hdr_rdata[HDR_W-1:pfcm_pkg::CNT_W];
  assign hdr_cnt = hdr_rdata[pfcm_pkg::CNT_W-1:0];

  assign qsize_next = (qsize_q < pfcm_pkg::MAX_TOKENS) ? qsize_q + 1'b1 : qsize_q;
  assign stat_o.q_usable_next = pfcm_pkg::usable(qsize_next, min_usable_i);

  // compare the stored token against every live query token
  always_comb begin
    match = 1'b0;
    for (int i = 0; i < pfcm_pkg::TOKENS_PER_PLACE; i++) begin
      if ((pfcm_pkg::CNT_W'(i) < qsize_q) && (q_tok_q[i] == tok_rdata)) begin
        match = 1'b1;
      end
    end
  end

  assign den = (hdr_cnt < qsize_q) ? hdr_cnt : qsize_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load && (qsize_q < pfcm_pkg::MAX_TOKENS)) begin
      q_tok_q[qsize_q[pfcm_pkg::SLOT_W-1:0]] <= item_i.token;
    end
    if (cmd_i.clr_hits) begin
      hits_q <= '0;
    end else if (cmd_i.acc_en && match && ({1'b0, cmd_i.acc_slot} < hdr_cnt)) begin
      hits_q <= hits_q + 1'b1;
    end
    if (cmd_i.score_en) begin
      score_q <= (pfcm_pkg::usable(hdr_cnt, min_usable_i) &&
                  pfcm_pkg::usable(qsize_q, min_usable_i)) ?
                 pfcm_pkg::score_of(hits_q, den) : '0;
    end
    if (cmd_i.done) begin
      result_q.found       <= found_q;
      result_q.best_index  <= best_idx_q;
      result_q.best_loc_id <= best_id_q;
      result_q.best_score  <= best_score_q;
      if (!found_q) begin
        result_q.relation <= pfcm_pkg::REL_NEW;
      end else if (best_score_q > known_threshold_i) begin
        result_q.relation <= pfcm_pkg::REL_KNOWN;
      end else if (best_score_q >= new_threshold_i) begin
        result_q.relation <= pfcm_pkg::REL_GRAY;
      end else begin
        result_q.relation <= pfcm_pkg::REL_NEW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qsize_q      <= '0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_score_q <= '0;
      best_id_q    <= '0;
      valid_q      <= 1'b0;
    end else begin
      valid_q <= cmd_i.done;
      if (cmd_i.done) begin
        qsize_q <= '0;
      end else if (cmd_i.q_load) begin
        qsize_q <= qsize_next;
      end
      if (cmd_i.clr_best) begin
        found_q      <= 1'b0;
        best_idx_q   <= '0;
        best_score_q <= '0;
        best_id_q    <= '0;
      end else if (cmd_i.cmp_en && (cmd_i.first || (score_q > best_score_q))) begin
        found_q      <= 1'b1;
        best_idx_q   <= cmd_i.place;
        best_score_q <= score_q;
        best_id_q    <= hdr_id;
      end
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

// ===== rtl/core/place_fingerprint_catalog_match_unit.sv =====
// catalog and query-token loads are taken in idle; only a closing query item raises busy
// a closing query item with a usable query walks the first min(count, 64) places (header and
// eight token reads from the catalog ram, then score and compare), then a finishing state
// the result strobe rises in the next cycle and lasts one cycle; the receiver cannot stall
// reset clears control state, the query fill count and the registers to 0, 3, 800 and 500
// catalog ram contents are not cleared and are undefined until written
`timescale 1ns / 1ps
`include "place_fingerprint_catalog_match_unit_assert.svh"
module place_fingerprint_catalog_match_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // item channel
  input  logic                    start,
  output logic                    busy,
  input  pfcm_pkg::item_t         item_i,
  // result channel
  output logic                    result_valid_o,
  output pfcm_pkg::result_t       result_o,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [1:0] REG_CATALOG_COUNT = 2'd0;
  localparam logic [1:0] REG_MIN_USABLE    = 2'd1;
  localparam logic [1:0] REG_KNOWN_THRESH  = 2'd2;
  localparam logic [1:0] REG_NEW_THRESH    = 2'd3;

  logic [pfcm_pkg::LIMIT_W-1:0] catalog_count_q;
  logic [pfcm_pkg::CNT_W-1:0]   min_usable_q;
  logic [pfcm_pkg::SCORE_W-1:0] known_threshold_q;
  logic [pfcm_pkg::SCORE_W-1:0] new_threshold_q;
  logic                         cfg_write;
  logic [1:0]                   reg_sel;

  pfcm_pkg::dp_cmd_t            dp_cmd;
  pfcm_pkg::dp_stat_t           dp_stat;

  // register file: word addressed, write in the access phase
  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      catalog_count_q   <= 7'd0;
      min_usable_q      <= 4'd3;
      known_threshold_q <= 10'd800;
      new_threshold_q   <= 10'd500;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CATALOG_COUNT: catalog_count_q   <= pwdata[pfcm_pkg::LIMIT_W-1:0];
        REG_MIN_USABLE:    min_usable_q      <= pwdata[pfcm_pkg::CNT_W-1:0];
        REG_KNOWN_THRESH:  known_threshold_q <= pwdata[pfcm_pkg::SCORE_W-1:0];
        REG_NEW_THRESH:    new_threshold_q   <= pwdata[pfcm_pkg::SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CATALOG_COUNT: prdata = 32'(catalog_count_q);
      REG_MIN_USABLE:    prdata = 32'(min_usable_q);
      REG_KNOWN_THRESH:  prdata = 32'(known_threshold_q);
      REG_NEW_THRESH:    prdata = 32'(new_threshold_q);
      default:           prdata = '0;
    endcase
  end

  // sequencer: loads in idle, then the place-by-place walk
  pfcm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .command_i       (item_i.command),
    .last_i          (item_i.last),
    .catalog_count_i (catalog_count_q),
    .stat_i          (dp_stat),
    .cmd_o           (dp_cmd),
    .busy_o          (busy)
  );

  // catalog rams, query tokens, overlap count, score and best tracking
  pfcm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .item_i            (item_i),
    .min_usable_i      (min_usable_q),
    .known_threshold_i (known_threshold_q),
    .new_threshold_i   (new_threshold_q),
    .stat_o            (dp_stat),
    .result_o          (result_o),
    .result_valid_o    (result_valid_o)
  );

  // a result leaves only once the walk is over
  `PFCM_ASSERT_IMPL(a_result_idle, clk_i, rst_ni, result_valid_o, !busy)
  // an unmatched query reports zeros
  `PFCM_ASSERT_IMPL(a_nofound_zero, clk_i, rst_ni, result_valid_o && !result_o.found,
                    (result_o.best_score == '0) && (result_o.best_index == '0))
  // permille never exceeds full scale
  `PFCM_ASSERT_IMPL(a_score_range, clk_i, rst_ni, result_valid_o,
                    result_o.best_score <= pfcm_pkg::SCORE_SCALE)
  // a closing query item always starts the search or result cycle
  `PFCM_ASSERT_NEXT(a_close_busy, clk_i, rst_ni,
                    start && !busy && (item_i.command == pfcm_pkg::CMD_QUERY) && item_i.last,
                    busy)

endmodule
